/* rtl/hceg_pkg.sv */
// ============================================================================
// hceg_pkg - shared types and constants for the hyperchaotic byte generator
// Fixed-point formats, beat structs, multiplier request/response and the
// micro-program that sequences one Euler step through the shared multiplier.
// ============================================================================
package hceg_pkg;

    // Default widths of the state (Q16.32) and coefficients (Q8.24)
    localparam int DEF_STATE_WIDTH = 48;
    localparam int DEF_COEF_WIDTH  = 32;

    // Datapath widths
    localparam int ACC_W    = 64;
    localparam int PROD_W   = 2 * ACC_W;
    localparam int HALF_W   = ACC_W / 2;
    localparam int SEED_W   = 48;
    localparam int SCALE_W  = 32;
    localparam int WARM_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int NUM_VARS = 4;
    localparam int NUM_COEF = 6;

    // Fraction bits and the Euler step multiplier
    localparam int FRAC_S = 32;
    localparam int FRAC_C = 24;
    localparam int HDT_SH = 52;
    localparam logic signed [ACC_W-1:0] HALF_DT_Q = 64'sd2251799813685;
    localparam logic signed [ACC_W-1:0] ONE_C     = 64'sd1 <<< FRAC_C;
    localparam logic signed [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

    // Partial products of the 64x64 magnitude multiply (32x32 each)
    localparam int PP_N     = 4;
    localparam int PP_CNT_W = $clog2(PP_N + 1);

    // Register reset values
    localparam logic signed [ACC_W-1:0] COEF_RESET [NUM_COEF] = '{
        64'sd503316480,
        64'sd503316,
        -64'sd20132659,
        64'sd838860800,
        64'sd5368709,
        64'sd1863949
    };
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 32'hFFFF_FFFF;
    localparam logic [WARM_W-1:0]  WARMUP_RESET = 16'd1000;

    // Register indexes
    typedef enum logic [2:0] {
        REG_A      = 3'd0,
        REG_B      = 3'd1,
        REG_C      = 3'd2,
        REG_D      = 3'd3,
        REG_E      = 3'd4,
        REG_F      = 3'd5,
        REG_SCALE  = 3'd6,
        REG_WARMUP = 3'd7
    } t_reg_idx;

    // Operation codes of an input beat
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [SEED_W-1:0] seed_0;
        logic signed [SEED_W-1:0] seed_1;
        logic signed [SEED_W-1:0] seed_2;
        logic signed [SEED_W-1:0] seed_3;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] rand_byte;
        logic              saturated;
    } t_out_beat;

    // Post-multiply shift selection
    typedef enum logic [1:0] {
        SH_C,
        SH_S,
        SH_DT
    } t_shift;

    typedef struct packed {
        logic                    start;
        t_shift                  shift;
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic                    sat;
        logic signed [ACC_W-1:0] p;
    } t_mul_rsp;

    // Operand sources
    typedef enum logic [4:0] {
        SRC_X0, SRC_X1, SRC_X2, SRC_X3,
        SRC_S, SRC_T,
        SRC_FD0, SRC_FD1, SRC_FD2, SRC_FD3,
        SRC_P,
        SRC_CA, SRC_CB, SRC_CD, SRC_CE, SRC_CF,
        SRC_C1, SRC_HDT, SRC_FRAC, SRC_SCALE
    } t_src;
    localparam int SRC_N = 20;

    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_ADD,
        ALU_SUB,
        ALU_ADD_CLIP,
        ALU_EMIT
    } t_alu;

    typedef enum logic [3:0] {
        DST_S, DST_T,
        DST_FD0, DST_FD1, DST_FD2, DST_FD3,
        DST_X0, DST_X1, DST_X2, DST_X3,
        DST_NONE
    } t_dst;

    typedef struct packed {
        logic   use_mul;
        t_src   mul_a;
        t_src   mul_b;
        t_shift shift;
        t_alu   alu;
        t_src   alu_a;
        t_src   alu_b;
        t_dst   dst;
    } t_uop;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_UPD_LAST = 4'd14;
    localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd15;

    function automatic t_uop mk_uop(input logic use_mul, input t_src mul_a,
                                    input t_src mul_b, input t_shift shift,
                                    input t_alu alu, input t_src alu_a,
                                    input t_src alu_b, input t_dst dst);
        t_uop u;
        u.use_mul = use_mul;
        u.mul_a   = mul_a;
        u.mul_b   = mul_b;
        u.shift   = shift;
        u.alu     = alu;
        u.alu_a   = alu_a;
        u.alu_b   = alu_b;
        u.dst     = dst;
        return u;
    endfunction

    // Micro-program of one integration step, then the output byte
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        unique case (step)
            // x0^2, x0^3
            4'd0:  u = mk_uop(1'b1, SRC_X0, SRC_X0, SH_S, ALU_PASS, SRC_P, SRC_P, DST_S);
            4'd1:  u = mk_uop(1'b1, SRC_S, SRC_X0, SH_S, ALU_PASS, SRC_P, SRC_P, DST_S);
            // f0 = a*(x1 - b*x0^3 - (1+c)*x0)
            4'd2:  u = mk_uop(1'b1, SRC_CB, SRC_S, SH_C, ALU_SUB, SRC_X1, SRC_P, DST_T);
            4'd3:  u = mk_uop(1'b1, SRC_C1, SRC_X0, SH_C, ALU_SUB, SRC_T, SRC_P, DST_T);
            4'd4:  u = mk_uop(1'b1, SRC_CA, SRC_T, SH_C, ALU_PASS, SRC_P, SRC_P, DST_FD0);
            // f1 = x0 - x1 + x2
            4'd5:  u = mk_uop(1'b0, SRC_P, SRC_P, SH_C, ALU_SUB, SRC_X0, SRC_X1, DST_S);
            4'd6:  u = mk_uop(1'b0, SRC_P, SRC_P, SH_C, ALU_ADD, SRC_S, SRC_X2, DST_FD1);
            // f2 = x3 - d*x1 - e*x2
            4'd7:  u = mk_uop(1'b1, SRC_CD, SRC_X1, SH_C, ALU_SUB, SRC_X3, SRC_P, DST_T);
            4'd8:  u = mk_uop(1'b1, SRC_CE, SRC_X2, SH_C, ALU_SUB, SRC_T, SRC_P, DST_FD2);
            // f3 = x1*x2 - f*x0
            4'd9:  u = mk_uop(1'b1, SRC_X1, SRC_X2, SH_S, ALU_PASS, SRC_P, SRC_P, DST_S);
            4'd10: u = mk_uop(1'b1, SRC_CF, SRC_X0, SH_C, ALU_SUB, SRC_S, SRC_P, DST_FD3);
            // xi += fi * dt/2
            4'd11: u = mk_uop(1'b1, SRC_FD0, SRC_HDT, SH_DT, ALU_ADD_CLIP,
                              SRC_X0, SRC_P, DST_X0);
            4'd12: u = mk_uop(1'b1, SRC_FD1, SRC_HDT, SH_DT, ALU_ADD_CLIP,
                              SRC_X1, SRC_P, DST_X1);
            4'd13: u = mk_uop(1'b1, SRC_FD2, SRC_HDT, SH_DT, ALU_ADD_CLIP,
                              SRC_X2, SRC_P, DST_X2);
            4'd14: u = mk_uop(1'b1, SRC_FD3, SRC_HDT, SH_DT, ALU_ADD_CLIP,
                              SRC_X3, SRC_P, DST_X3);
            // byte = (frac(|x0|) * scale) >> 32
            4'd15: u = mk_uop(1'b1, SRC_FRAC, SRC_SCALE, SH_S, ALU_EMIT,
                              SRC_P, SRC_P, DST_NONE);
            default: u = mk_uop(1'b0, SRC_P, SRC_P, SH_C, ALU_PASS, SRC_P, SRC_P, DST_NONE);
        endcase
        return u;
    endfunction

endpackage

/* rtl/hceg_mul.sv */
// ============================================================================
// hceg_mul - shared iterative signed multiplier with shift and saturation
// Forms |a|*|b| from four 32x32 partial products, restores the sign, shifts
// right with floor by 24, 32 or 52 bits and saturates the result to 64 bits.
// ============================================================================
module hceg_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hceg_pkg::t_mul_req  i_req,
    output hceg_pkg::t_mul_rsp  o_rsp
);
    import hceg_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MUL  = 4'b0010,
        M_NEG  = 4'b0100,
        M_FIN  = 4'b1000
    } t_mstate;

    t_mstate                 r_state, n_state;
    logic [PP_CNT_W-1:0]     r_cnt, n_cnt;
    logic [ACC_W-1:0]        r_ua, n_ua;
    logic [ACC_W-1:0]        r_ub, n_ub;
    logic                    r_neg, n_neg;
    t_shift                  r_shift, n_shift;
    logic [ACC_W-1:0]        r_pp, n_pp;
    logic [1:0]              r_pp_w, n_pp_w;
    logic [PROD_W-1:0]       r_acc, n_acc;
    logic                    r_done, n_done;
    logic                    r_sat, n_sat;
    logic signed [ACC_W-1:0] r_p, n_p;

    logic [HALF_W-1:0]        w_ha;
    logic [HALF_W-1:0]        w_hb;
    logic [ACC_W-1:0]         w_pp;
    logic [PROD_W-1:0]        w_term;
    logic signed [PROD_W-1:0] w_shd;
    logic [PROD_W-ACC_W:0]    w_top;
    logic                     w_fits;

    // Pick the halves for the current partial product
    always_comb begin
        w_ha   = r_cnt[1] ? r_ua[ACC_W-1:HALF_W] : r_ua[HALF_W-1:0];
        w_hb   = r_cnt[0] ? r_ub[ACC_W-1:HALF_W] : r_ub[HALF_W-1:0];
        w_pp   = ACC_W'(w_ha) * ACC_W'(w_hb);
        w_term = PROD_W'(r_pp) << (HALF_W * r_pp_w);
    end

    // Floor shift of the signed product and 64-bit range check
    always_comb begin
        unique case (r_shift)
            SH_C:    w_shd = $signed(r_acc) >>> FRAC_C;
            SH_S:    w_shd = $signed(r_acc) >>> FRAC_S;
            SH_DT:   w_shd = $signed(r_acc) >>> HDT_SH;
            default: w_shd = $signed(r_acc) >>> FRAC_S;
        endcase
        w_top  = w_shd[PROD_W-1:ACC_W-1];
        w_fits = (&w_top) | ~(|w_top);
    end

    // Sequence: capture magnitudes, accumulate, restore sign, shift
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ua    = r_ua;
        n_ub    = r_ub;
        n_neg   = r_neg;
        n_shift = r_shift;
        n_pp    = r_pp;
        n_pp_w  = r_pp_w;
        n_acc   = r_acc;
        n_done  = 1'b0;
        n_sat   = r_sat;
        n_p     = r_p;
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_ua    = i_req.a[ACC_W-1] ? (~i_req.a + 1'b1) : i_req.a;
                    n_ub    = i_req.b[ACC_W-1] ? (~i_req.b + 1'b1) : i_req.b;
                    n_neg   = i_req.a[ACC_W-1] ^ i_req.b[ACC_W-1];
                    n_shift = i_req.shift;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = M_MUL;
                end
            end
            M_MUL: begin
                // register one partial product, accumulate the previous one
                if (r_cnt < PP_CNT_W'(PP_N)) begin
                    n_pp   = w_pp;
                    n_pp_w = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                end
                if (r_cnt != '0) begin
                    n_acc = r_acc + w_term;
                end
                if (r_cnt == PP_CNT_W'(PP_N)) begin
                    n_state = M_NEG;
                end
                n_cnt = r_cnt + 1'b1;
            end
            M_NEG: begin
                if (r_neg) begin
                    n_acc = ~r_acc + 1'b1;
                end
                n_state = M_FIN;
            end
            M_FIN: begin
                n_p     = w_fits ? w_shd[ACC_W-1:0] : (w_shd[PROD_W-1] ? ACC_MIN : ACC_MAX);
                n_sat   = ~w_fits;
                n_done  = 1'b1;
                n_state = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ua    <= n_ua;
        r_ub    <= n_ub;
        r_neg   <= n_neg;
        r_shift <= n_shift;
        r_pp    <= n_pp;
        r_pp_w  <= n_pp_w;
        r_acc   <= n_acc;
        r_sat   <= n_sat;
        r_p     <= n_p;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.p    = r_p;

endmodule

/* rtl/hyperchaotic_euler_byte_generator.sv */
// ============================================================================
// hyperchaotic_euler_byte_generator - four-variable hyperchaotic byte source
// Euler-integrated 4D hyperchaotic system in fixed point that emits one
// pseudo-random byte per integration step once the warm-up has run out.
// ============================================================================
// A restart beat (op 0) loads the four Q16.32 seeds and arms the warm-up count
// and returns nothing. A step beat (op 1) runs one Euler step through a
// single shared 64x64 multiplier; a step needs thirteen products and two add
// steps, plus one more product for the output byte when warm-up is over. The
// input is not ready while a step is in flight; a finished byte waits in the
// output register while the next beat is taken. Every intermediate saturates
// to 64 bits and the state to STATE_WIDTH bits; any clip during a step raises
// the saturated flag of its result.
module hyperchaotic_euler_byte_generator #(
    parameter int STATE_WIDTH = hceg_pkg::DEF_STATE_WIDTH,
    parameter int COEF_WIDTH  = hceg_pkg::DEF_COEF_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  hceg_pkg::t_in_beat    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output hceg_pkg::t_out_beat   o_out_data,
    input  logic                  i_cfg_we,
    input  hceg_pkg::t_reg_idx    i_cfg_index,
    input  logic [((COEF_WIDTH > hceg_pkg::SCALE_W) ? COEF_WIDTH : hceg_pkg::SCALE_W)-1:0]
                                  i_cfg_data
);
    import hceg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EXEC  = 4'b1000
    } t_state;

    localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    // Configuration registers
    logic signed [COEF_WIDTH-1:0] r_coef [NUM_COEF];
    logic [SCALE_W-1:0]           r_scale;
    logic [WARM_W-1:0]            r_warm_cfg;

    // Sequencer and state
    t_state                        r_state, n_state;
    logic [STEP_W-1:0]             r_step, n_step;
    logic                          r_sat, n_sat;
    logic [WARM_W-1:0]             r_warm_left, n_warm_left;
    logic signed [STATE_WIDTH-1:0] r_x [NUM_VARS];
    logic signed [STATE_WIDTH-1:0] n_x [NUM_VARS];
    logic signed [ACC_W-1:0]       r_s, n_s;
    logic signed [ACC_W-1:0]       r_t, n_t;
    logic signed [ACC_W-1:0]       r_fd [NUM_VARS];
    logic signed [ACC_W-1:0]       n_fd [NUM_VARS];
    logic                          r_out_valid, n_out_valid;
    t_out_beat                     r_out_data, n_out_data;

    // Datapath wires
    t_uop                    w_uop;
    t_uop                    w_next_uop;
    t_mul_req                w_req;
    t_mul_rsp                w_rsp;
    logic signed [ACC_W-1:0] w_x64 [NUM_VARS];
    logic signed [ACC_W-1:0] w_seed [NUM_VARS];
    logic signed [ACC_W-1:0] w_src [SRC_N];
    logic [HALF_W-1:0]       w_mag_lo;
    logic signed [ACC_W-1:0] w_a;
    logic signed [ACC_W-1:0] w_b;
    logic signed [ACC_W:0]   w_sum;
    logic                    w_ovf;
    logic signed [ACC_W-1:0] w_sat_val;
    logic signed [ACC_W-1:0] w_res;
    logic signed [STATE_WIDTH-1:0] w_res_state;
    logic                    w_alu_sat;

    function automatic logic fits_state(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-STATE_WIDTH:0] top;
        top = v[ACC_W-1:STATE_WIDTH-1];
        return (&top) | ~(|top);
    endfunction

    function automatic logic signed [STATE_WIDTH-1:0] clip_state(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [STATE_WIDTH-1:0] r;
        if (fits_state(v)) begin
            r = v[STATE_WIDTH-1:0];
        end else begin
            r = v[ACC_W-1] ? STATE_MIN : STATE_MAX;
        end
        return r;
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= COEF_RESET[k][COEF_WIDTH-1:0];
            end
            r_scale    <= SCALE_RESET;
            r_warm_cfg <= WARMUP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                REG_A, REG_B, REG_C, REG_D, REG_E, REG_F: begin
                    r_coef[3'(i_cfg_index)] <= i_cfg_data[COEF_WIDTH-1:0];
                end
                REG_SCALE:  r_scale    <= i_cfg_data[SCALE_W-1:0];
                REG_WARMUP: r_warm_cfg <= i_cfg_data[WARM_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the current and following micro-op
    assign w_uop      = uop_rom(r_step);
    assign w_next_uop = uop_rom(r_step + 1'b1);

    // Widen state and seeds, build the operand sources
    always_comb begin
        for (int k = 0; k < NUM_VARS; k++) begin
            w_x64[k] = ACC_W'(r_x[k]);
        end
        w_seed[0] = ACC_W'($signed(i_in_data.seed_0));
        w_seed[1] = ACC_W'($signed(i_in_data.seed_1));
        w_seed[2] = ACC_W'($signed(i_in_data.seed_2));
        w_seed[3] = ACC_W'($signed(i_in_data.seed_3));
        w_mag_lo  = w_x64[0][ACC_W-1] ? (~w_x64[0][HALF_W-1:0] + 1'b1)
                                      : w_x64[0][HALF_W-1:0];

        w_src[SRC_X0]    = w_x64[0];
        w_src[SRC_X1]    = w_x64[1];
        w_src[SRC_X2]    = w_x64[2];
        w_src[SRC_X3]    = w_x64[3];
        w_src[SRC_S]     = r_s;
        w_src[SRC_T]     = r_t;
        w_src[SRC_FD0]   = r_fd[0];
        w_src[SRC_FD1]   = r_fd[1];
        w_src[SRC_FD2]   = r_fd[2];
        w_src[SRC_FD3]   = r_fd[3];
        w_src[SRC_P]     = w_rsp.p;
        w_src[SRC_CA]    = ACC_W'(r_coef[0]);
        w_src[SRC_CB]    = ACC_W'(r_coef[1]);
        w_src[SRC_CD]    = ACC_W'(r_coef[3]);
        w_src[SRC_CE]    = ACC_W'(r_coef[4]);
        w_src[SRC_CF]    = ACC_W'(r_coef[5]);
        w_src[SRC_C1]    = ONE_C + ACC_W'(r_coef[2]);
        w_src[SRC_HDT]   = HALF_DT_Q;
        w_src[SRC_FRAC]  = {{(ACC_W-HALF_W){1'b0}}, w_mag_lo};
        w_src[SRC_SCALE] = {{(ACC_W-SCALE_W){1'b0}}, r_scale};
    end

    // Multiplier request
    always_comb begin
        w_req.start = (r_state == ST_ISSUE);
        w_req.shift = w_uop.shift;
        w_req.a     = w_src[w_uop.mul_a];
        w_req.b     = w_src[w_uop.mul_b];
    end

    hceg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Saturating add/subtract, optional clip to state width
    always_comb begin
        w_a = w_src[w_uop.alu_a];
        w_b = w_src[w_uop.alu_b];
        if (w_uop.alu == ALU_SUB) begin
            w_sum = {w_a[ACC_W-1], w_a} - {w_b[ACC_W-1], w_b};
        end else begin
            w_sum = {w_a[ACC_W-1], w_a} + {w_b[ACC_W-1], w_b};
        end
        w_ovf       = w_sum[ACC_W] ^ w_sum[ACC_W-1];
        w_sat_val   = w_ovf ? (w_sum[ACC_W] ? ACC_MIN : ACC_MAX) : w_sum[ACC_W-1:0];
        w_res_state = clip_state(w_sat_val);
        unique case (w_uop.alu)
            ALU_ADD, ALU_SUB: begin
                w_res     = w_sat_val;
                w_alu_sat = w_ovf;
            end
            ALU_ADD_CLIP: begin
                w_res     = w_sat_val;
                w_alu_sat = w_ovf | ~fits_state(w_sat_val);
            end
            default: begin
                w_res     = w_a;
                w_alu_sat = 1'b0;
            end
        endcase
    end

    // Sequencer: accept, issue products, write back, emit
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sat       = r_sat;
        n_warm_left = r_warm_left;
        n_x         = r_x;
        n_s         = r_s;
        n_t         = r_t;
        n_fd        = r_fd;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // drop the output beat once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.op == OP_RESTART) begin
                        for (int k = 0; k < NUM_VARS; k++) begin
                            n_x[k] = clip_state(w_seed[k]);
                        end
                        n_warm_left = r_warm_cfg;
                    end else begin
                        n_step  = '0;
                        n_sat   = 1'b0;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT: begin
                if (w_rsp.done) begin
                    n_sat   = r_sat | w_rsp.sat;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_uop.alu == ALU_EMIT) begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        n_out_valid          = 1'b1;
                        n_out_data.rand_byte = w_a[BYTE_W-1:0];
                        n_out_data.saturated = r_sat;
                        n_state              = ST_IDLE;
                    end
                end else begin
                    n_sat = r_sat | w_alu_sat;
                    unique case (w_uop.dst)
                        DST_S:   n_s     = w_res;
                        DST_T:   n_t     = w_res;
                        DST_FD0: n_fd[0] = w_res;
                        DST_FD1: n_fd[1] = w_res;
                        DST_FD2: n_fd[2] = w_res;
                        DST_FD3: n_fd[3] = w_res;
                        DST_X0:  n_x[0]  = w_res_state;
                        DST_X1:  n_x[1]  = w_res_state;
                        DST_X2:  n_x[2]  = w_res_state;
                        DST_X3:  n_x[3]  = w_res_state;
                        default: ;
                    endcase
                    if (r_step == STEP_UPD_LAST) begin
                        if (r_warm_left != '0) begin
                            n_warm_left = r_warm_left - 1'b1;
                            n_state     = ST_IDLE;
                        end else begin
                            n_step  = STEP_EMIT;
                            n_state = ST_ISSUE;
                        end
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = w_next_uop.use_mul ? ST_ISSUE : ST_EXEC;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_sat       <= 1'b0;
            r_warm_left <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_VARS; k++) begin
                r_x[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_sat       <= n_sat;
            r_warm_left <= n_warm_left;
            r_out_valid <= n_out_valid;
            r_x         <= n_x;
        end
    end

    // Scratch and output payload registers
    always_ff @(posedge i_clk) begin
        r_s        <= n_s;
        r_t        <= n_t;
        r_fd       <= n_fd;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
